/* sv/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the shutter travel calibrator.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int TIME_BITS_DEF = 16;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int CUR_BITS      = 13;
  localparam int THR_BITS      = 12;
  localparam int MS_BITS       = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CURRENT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVER_TORQUE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TRAVEL    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_OPEN    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRAVEL_TMO    = 3'd4;

  // configuration reset values
  localparam logic [THR_BITS-1:0] MAX_CURRENT_RST = 12'd30;
  localparam logic [MS_BITS-1:0]  OVER_TORQUE_RST = 16'd0;
  localparam logic [MS_BITS-1:0]  MIN_TRAVEL_RST  = 16'd1000;
  localparam logic [MS_BITS-1:0]  FIRST_OPEN_RST  = 16'd5000;
  localparam logic [MS_BITS-1:0]  TRAVEL_TMO_RST  = 16'd30000;

  localparam logic [7:0]         SPEED_FULL = 8'd255;
  localparam logic [7:0]         SPEED_OFF  = 8'd0;
  localparam logic [MS_BITS-1:0] MS_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_CONFIRM = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE         = 5'd0,
    ST_BEGIN        = 5'd1,
    ST_PROBE_OPEN   = 5'd2,
    ST_WAIT_CONFIRM = 5'd3,
    ST_START_CLOSE  = 5'd4,
    ST_CLOSING      = 5'd5,
    ST_START_TOPEN  = 5'd6,
    ST_TIMED_OPEN   = 5'd7,
    ST_RETRY_OPEN   = 5'd8,
    ST_START_REOPEN = 5'd9,
    ST_REOPENING    = 5'd10,
    ST_START_TCLOSE = 5'd11,
    ST_TIMED_CLOSE  = 5'd12,
    ST_RETRY_CLOSE  = 5'd13,
    ST_START_PARK   = 5'd14,
    ST_PARKING      = 5'd15,
    ST_ERROR        = 5'd17
  } step_t;

  typedef struct packed {
    step_t step;
    logic  open_latch;
    logic  close_latch;
    logic  drive_dir;
    logic  drive_on;
  } ctl_t;

  typedef struct packed {
    logic [THR_BITS-1:0] max_current;
    logic [MS_BITS-1:0]  over_torque;
    logic [MS_BITS-1:0]  min_travel;
    logic [MS_BITS-1:0]  first_open;
    logic [MS_BITS-1:0]  travel_tmo;
  } cfg_t;

endpackage

/* sv/stc_step.sv */
// ----------------------------------------------------------------------------
// stc_step
// Next-state logic for one tick: command, stop detectors, sequencer step.
// ----------------------------------------------------------------------------
module stc_step import stc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  cmd_t                       cmd_i,
  input  logic signed [CUR_BITS-1:0] current_i,
  input  cfg_t                       cfg_i,
  input  ctl_t                       ctl_i,
  input  logic [TIME_BITS-1:0]       phase_i,
  input  logic [TIME_BITS-1:0]       open_hold_i,
  input  logic [TIME_BITS-1:0]       close_hold_i,
  input  logic [MS_BITS-1:0]         open_time_i,
  input  logic [MS_BITS-1:0]         close_time_i,
  input  logic [MS_BITS-1:0]         saved_open_i,
  input  logic [MS_BITS-1:0]         saved_close_i,
  output ctl_t                       ctl_o,
  output logic [TIME_BITS-1:0]       phase_o,
  output logic [TIME_BITS-1:0]       open_hold_o,
  output logic [TIME_BITS-1:0]       close_hold_o,
  output logic [MS_BITS-1:0]         open_time_o,
  output logic [MS_BITS-1:0]         close_time_o,
  output logic                       save_en_o,
  output logic                       done_o
);

  localparam int CW = ((TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS) + 2;

  function automatic ctl_t bridge(ctl_t c, logic dir, logic on);
    ctl_t r;
    r = c;
    r.drive_dir = dir;
    r.drive_on  = on;
    if (!dir) begin
      r.open_latch = 1'b0;
    end else begin
      r.close_latch = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_inc(logic [TIME_BITS-1:0] v);
    return (&v) ? v : v + TIME_BITS'(1);
  endfunction

  function automatic logic [CW-1:0] ext_ms(logic [MS_BITS-1:0] v);
    return {{(CW-MS_BITS){1'b0}}, v};
  endfunction

  function automatic logic [CW-1:0] ext_t(logic [TIME_BITS-1:0] v);
    return {{(CW-TIME_BITS){1'b0}}, v};
  endfunction

  logic signed [CUR_BITS:0] cur_x;
  logic signed [CUR_BITS:0] cur_neg;
  logic signed [CUR_BITS:0] thr_x;
  logic                     pos_over;
  logic                     neg_over;
  logic [CW-1:0]            hold_limit;
  logic [TIME_BITS-1:0]     ph_inc;
  logic [CW-1:0]            ph_ext;
  logic [MS_BITS-1:0]       meas;
  logic                     past_first;
  logic                     past_tmo;

  assign cur_x    = {current_i[CUR_BITS-1], current_i};
  assign cur_neg  = -cur_x;
  assign thr_x    = $signed({2'b00, cfg_i.max_current});
  assign pos_over = cur_x > thr_x;
  assign neg_over = cur_neg > thr_x;
  // latch once the hold count minus one exceeds the hold time
  assign hold_limit = ext_ms(cfg_i.over_torque) + CW'(1);

  assign ph_inc     = sat_inc(phase_i);
  assign ph_ext     = ext_t(ph_inc);
  assign meas       = (ph_ext > ext_ms(MS_MAX)) ? MS_MAX : ph_ext[MS_BITS-1:0];
  assign past_first = ph_ext > ext_ms(cfg_i.first_open);
  assign past_tmo   = ph_ext > ext_ms(cfg_i.travel_tmo);

  always_comb begin
    ctl_o        = ctl_i;
    phase_o      = phase_i;
    open_time_o  = open_time_i;
    close_time_o = close_time_i;
    save_en_o    = 1'b0;
    done_o       = 1'b0;

    unique case (cmd_i)
      CMD_START: begin
        ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
        ctl_o.step = ST_BEGIN;
      end
      CMD_CONFIRM: begin
        if (ctl_o.step == ST_WAIT_CONFIRM) begin
          ctl_o.step = ST_START_CLOSE;
        end
      end
      CMD_CANCEL: begin
        if (ctl_o.step != ST_IDLE) begin
          ctl_o        = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step   = ST_IDLE;
          open_time_o  = saved_open_i;
          close_time_o = saved_close_i;
        end
      end
      default: ;
    endcase

    // stop detectors
    if (pos_over) begin
      open_hold_o = sat_inc(open_hold_i);
      if (ext_t(open_hold_o) > hold_limit) begin
        ctl_o.open_latch = 1'b1;
      end
    end else begin
      open_hold_o = '0;
    end
    if (neg_over) begin
      close_hold_o = sat_inc(close_hold_i);
      if (ext_t(close_hold_o) > hold_limit) begin
        ctl_o.close_latch = 1'b1;
      end
    end else begin
      close_hold_o = '0;
    end

    unique case (ctl_o.step)
      ST_IDLE, ST_WAIT_CONFIRM, ST_ERROR: ;
      ST_BEGIN: begin
        save_en_o  = 1'b1;
        ctl_o      = bridge(ctl_o, 1'b1, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_PROBE_OPEN;
      end
      ST_PROBE_OPEN: begin
        phase_o = ph_inc;
        if (ctl_o.open_latch || past_first) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_WAIT_CONFIRM;
        end
      end
      ST_START_CLOSE: begin
        ctl_o      = bridge(ctl_o, 1'b0, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_CLOSING;
      end
      ST_CLOSING: begin
        phase_o = ph_inc;
        if (ctl_o.close_latch) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_START_TOPEN;
        end else if (past_tmo) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_ERROR;
        end
      end
      ST_START_TOPEN: begin
        ctl_o      = bridge(ctl_o, 1'b1, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_TIMED_OPEN;
      end
      ST_TIMED_OPEN: begin
        phase_o = ph_inc;
        if (ctl_o.open_latch) begin
          ctl_o       = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          open_time_o = meas;
          ctl_o.step  = (meas < cfg_i.min_travel) ? ST_RETRY_OPEN : ST_START_REOPEN;
        end else if (past_tmo) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_ERROR;
        end
      end
      ST_RETRY_OPEN: ctl_o.step = ST_START_CLOSE;
      ST_START_REOPEN: begin
        ctl_o      = bridge(ctl_o, 1'b1, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_REOPENING;
      end
      ST_REOPENING: begin
        phase_o = ph_inc;
        if (ctl_o.open_latch) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_START_TCLOSE;
        end else if (past_tmo) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_ERROR;
        end
      end
      ST_START_TCLOSE: begin
        ctl_o      = bridge(ctl_o, 1'b0, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_TIMED_CLOSE;
      end
      ST_TIMED_CLOSE: begin
        phase_o = ph_inc;
        if (ctl_o.close_latch) begin
          ctl_o        = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          close_time_o = meas;
          ctl_o.step   = (meas < cfg_i.min_travel) ? ST_RETRY_CLOSE : ST_START_PARK;
        end else if (past_tmo) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_ERROR;
        end
      end
      ST_RETRY_CLOSE: ctl_o.step = ST_START_REOPEN;
      ST_START_PARK: begin
        ctl_o      = bridge(ctl_o, 1'b1, 1'b1);
        phase_o    = '0;
        ctl_o.step = ST_PARKING;
      end
      ST_PARKING: begin
        phase_o = ph_inc;
        if (past_first) begin
          ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
          ctl_o.step = ST_IDLE;
          done_o     = 1'b1;
        end
      end
      default: begin
        // undefined step code: stop and report error
        ctl_o      = bridge(ctl_o, ctl_o.drive_dir, 1'b0);
        ctl_o.step = ST_ERROR;
      end
    endcase
  end

endmodule

/* sv/shutter_travel_calibrator_top.sv */
// ----------------------------------------------------------------------------
// shutter_travel_calibrator_top
// A result beat is registered and appears in the cycle after its input beat
// is taken. Throughput: one input beat per cycle unless a result beat stalls;
// the step logic is a single pass between state and output registers.
// Reset: synchronous, active low; clears the sequencer to idle, the timers,
// latches and travel times, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module shutter_travel_calibrator_top import stc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic signed [CUR_BITS-1:0] in_current_ma,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_motor_dir,
  output logic [7:0]                out_motor_speed,
  output logic [4:0]                out_step_code,
  output logic                      out_waiting_confirm,
  output logic                      out_busy_res,
  output logic                      out_fault,
  output logic                      out_finished,
  output logic [MS_BITS-1:0]        out_open_time_ms,
  output logic [MS_BITS-1:0]        out_close_time_ms,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                 cfg_r;
  ctl_t                 ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] phase_r, phase_nxt;
  logic [TIME_BITS-1:0] open_hold_r, open_hold_nxt;
  logic [TIME_BITS-1:0] close_hold_r, close_hold_nxt;
  logic [MS_BITS-1:0]   open_time_r, open_time_nxt;
  logic [MS_BITS-1:0]   close_time_r, close_time_nxt;
  logic [MS_BITS-1:0]   saved_open_r, saved_close_r;
  logic                 save_en;
  logic                 done;
  logic                 in_fire;
  logic                 out_valid_r;

  logic                 dir_r;
  logic                 on_r;
  step_t                step_r;
  logic                 done_r;
  logic [MS_BITS-1:0]   open_out_r, close_out_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_current <= MAX_CURRENT_RST;
      cfg_r.over_torque <= OVER_TORQUE_RST;
      cfg_r.min_travel  <= MIN_TRAVEL_RST;
      cfg_r.first_open  <= FIRST_OPEN_RST;
      cfg_r.travel_tmo  <= TRAVEL_TMO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_CURRENT: cfg_r.max_current <= cfg_data[THR_BITS-1:0];
        CFG_OVER_TORQUE: cfg_r.over_torque <= cfg_data;
        CFG_MIN_TRAVEL:  cfg_r.min_travel  <= cfg_data;
        CFG_FIRST_OPEN:  cfg_r.first_open  <= cfg_data;
        CFG_TRAVEL_TMO:  cfg_r.travel_tmo  <= cfg_data;
        default: ;
      endcase
    end
  end

  stc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cmd_i        (cmd_t'(in_cmd)),
    .current_i    (in_current_ma),
    .cfg_i        (cfg_r),
    .ctl_i        (ctl_r),
    .phase_i      (phase_r),
    .open_hold_i  (open_hold_r),
    .close_hold_i (close_hold_r),
    .open_time_i  (open_time_r),
    .close_time_i (close_time_r),
    .saved_open_i (saved_open_r),
    .saved_close_i(saved_close_r),
    .ctl_o        (ctl_nxt),
    .phase_o      (phase_nxt),
    .open_hold_o  (open_hold_nxt),
    .close_hold_o (close_hold_nxt),
    .open_time_o  (open_time_nxt),
    .close_time_o (close_time_nxt),
    .save_en_o    (save_en),
    .done_o       (done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= '{step: ST_IDLE, default: 1'b0};
      phase_r      <= '0;
      open_hold_r  <= '0;
      close_hold_r <= '0;
      open_time_r  <= '0;
      close_time_r <= '0;
    end else if (in_fire) begin
      ctl_r        <= ctl_nxt;
      phase_r      <= phase_nxt;
      open_hold_r  <= open_hold_nxt;
      close_hold_r <= close_hold_nxt;
      open_time_r  <= open_time_nxt;
      close_time_r <= close_time_nxt;
    end
  end

  // saved times are snapshots of the times present when a run begins
  always_ff @(posedge clk) begin
    if (in_fire && save_en) begin
      saved_open_r  <= open_time_r;
      saved_close_r <= close_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dir_r       <= ctl_nxt.drive_dir;
      on_r        <= ctl_nxt.drive_on;
      step_r      <= ctl_nxt.step;
      done_r      <= done;
      open_out_r  <= open_time_nxt;
      close_out_r <= close_time_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_dir       = dir_r;
  assign out_motor_speed     = on_r ? SPEED_FULL : SPEED_OFF;
  assign out_step_code       = step_r;
  assign out_waiting_confirm = (step_r == ST_WAIT_CONFIRM);
  assign out_busy_res        = (step_r != ST_IDLE);
  assign out_fault           = (step_r == ST_ERROR);
  assign out_finished        = done_r;
  assign out_open_time_ms    = open_out_r;
  assign out_close_time_ms   = close_out_r;

endmodule

/* sv/stc_checker.sv */
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks on the calibrator result channel.
// ----------------------------------------------------------------------------
module stc_checker import stc_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_cmd,
  input logic signed [CUR_BITS-1:0] in_current_ma,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_motor_dir,
  input logic [7:0]                 out_motor_speed,
  input logic [4:0]                 out_step_code,
  input logic                       out_waiting_confirm,
  input logic                       out_busy_res,
  input logic                       out_fault,
  input logic                       out_finished,
  input logic [MS_BITS-1:0]         out_open_time_ms,
  input logic [MS_BITS-1:0]         out_close_time_ms,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_IDX_BITS-1:0]    cfg_index,
  input logic [CFG_DATA_BITS-1:0]   cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_code)
      && $stable(out_open_time_ms) && $stable(out_close_time_ms))
    else $error("stalled result beat changed");

  // the motor only runs while a calibration run is active
  a_run_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_speed != SPEED_OFF |-> out_busy_res && !out_fault
      && !out_waiting_confirm)
    else $error("motor driven outside an active move");

  // completion pulse lands on idle with the motor off
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_step_code == ST_IDLE
      && out_motor_speed == SPEED_OFF)
    else $error("finish pulse outside idle");

  // error step reports fault and stays busy
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_busy_res && out_step_code == ST_ERROR)
    else $error("fault flag inconsistent with step");

endmodule

bind shutter_travel_calibrator_top stc_checker u_stc_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the shutter travel calibrator. A behavioral copy of the
// sequencer predicts the status beat of every accepted tick, and the
// returned beats are compared field by field in order. A simple leaf model
// picks the motor current from the predicted drive, so the runs go through
// whole calibrations, retries, timeouts, restarts and cancels, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import stc_pkg::*;

  localparam int LIMIT = 1500000;

  typedef logic signed [CUR_BITS-1:0] cur_t;

  typedef struct packed {
    logic                dir;
    logic [7:0]          speed;
    logic [4:0]          step;
    logic                waiting;
    logic                busy;
    logic                fault;
    logic                done;
    logic [MS_BITS-1:0]  open_ms;
    logic [MS_BITS-1:0]  close_ms;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_cmd = CMD_TICK;
  cur_t                     in_current_ma = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_motor_dir;
  logic [7:0]               out_motor_speed;
  logic [4:0]               out_step_code;
  logic                     out_waiting_confirm;
  logic                     out_busy_res;
  logic                     out_fault;
  logic                     out_finished;
  logic [MS_BITS-1:0]       out_open_time_ms;
  logic [MS_BITS-1:0]       out_close_time_ms;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_MAX_CURRENT;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // sequencer copy
  step_t              seq_step = ST_IDLE;
  logic [MS_BITS-1:0] phase_ms = '0;
  logic [MS_BITS-1:0] open_hold_ms = '0;
  logic [MS_BITS-1:0] close_hold_ms = '0;
  logic               open_stop = 1'b0;
  logic               close_stop = 1'b0;
  logic               drv_dir = 1'b0;
  logic               drv_on = 1'b0;
  logic [MS_BITS-1:0] open_ms = '0;
  logic [MS_BITS-1:0] close_ms = '0;
  logic [MS_BITS-1:0] saved_open_ms = '0;
  logic [MS_BITS-1:0] saved_close_ms = '0;

  logic [THR_BITS-1:0] thr_ma = MAX_CURRENT_RST;
  logic [MS_BITS-1:0]  torque_ms = OVER_TORQUE_RST;
  logic [MS_BITS-1:0]  min_ms = MIN_TRAVEL_RST;
  logic [MS_BITS-1:0]  probe_ms = FIRST_OPEN_RST;
  logic [MS_BITS-1:0]  tmo_ms = TRAVEL_TMO_RST;

  status_t pending_status[$];

  // leaf model
  int travel_left = 0;
  int travel_span = 8;
  bit was_on = 1'b0;
  bit was_dir = 1'b0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int items_sent = 0;
  int beat_no = 0;
  int mismatches = 0;
  int cycle_count = 0;

  shutter_travel_calibrator_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_current_ma       (in_current_ma),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_dir       (out_motor_dir),
    .out_motor_speed     (out_motor_speed),
    .out_step_code       (out_step_code),
    .out_waiting_confirm (out_waiting_confirm),
    .out_busy_res        (out_busy_res),
    .out_fault           (out_fault),
    .out_finished        (out_finished),
    .out_open_time_ms    (out_open_time_ms),
    .out_close_time_ms   (out_close_time_ms),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [MS_BITS-1:0] sat_ms(input logic [MS_BITS-1:0] v);
    return (v == MS_MAX) ? v : v + 1'b1;
  endfunction

  // every drive change releases the stop on the other side
  task automatic set_bridge(input logic dir, input logic on);
    drv_dir = dir;
    drv_on = on;
    if (!dir) open_stop = 1'b0;
    else close_stop = 1'b0;
  endtask

  task automatic start_move(input logic dir, input step_t nxt);
    set_bridge(dir, 1'b1);
    phase_ms = '0;
    seq_step = nxt;
  endtask

  task automatic halt_fault();
    set_bridge(drv_dir, 1'b0);
    seq_step = ST_ERROR;
  endtask

  task automatic advance_sequencer(input cmd_t cmd, input cur_t cur);
    int c;
    logic fin;
    status_t st;
    c = cur;
    fin = 1'b0;
    case (cmd)
      CMD_START: begin
        set_bridge(drv_dir, 1'b0);
        seq_step = ST_BEGIN;
      end
      CMD_CONFIRM: begin
        if (seq_step == ST_WAIT_CONFIRM) seq_step = ST_START_CLOSE;
      end
      CMD_CANCEL: begin
        if (seq_step != ST_IDLE) begin
          set_bridge(drv_dir, 1'b0);
          seq_step = ST_IDLE;
          open_ms = saved_open_ms;
          close_ms = saved_close_ms;
        end
      end
      default: ;
    endcase

    if (c > int'(thr_ma)) begin
      open_hold_ms = sat_ms(open_hold_ms);
      if (int'(open_hold_ms) > int'(torque_ms) + 1) open_stop = 1'b1;
    end else begin
      open_hold_ms = '0;
    end
    if (-c > int'(thr_ma)) begin
      close_hold_ms = sat_ms(close_hold_ms);
      if (int'(close_hold_ms) > int'(torque_ms) + 1) close_stop = 1'b1;
    end else begin
      close_hold_ms = '0;
    end

    case (seq_step)
      ST_IDLE, ST_WAIT_CONFIRM, ST_ERROR: ;
      ST_BEGIN: begin
        saved_open_ms = open_ms;
        saved_close_ms = close_ms;
        start_move(1'b1, ST_PROBE_OPEN);
      end
      ST_PROBE_OPEN: begin
        phase_ms = sat_ms(phase_ms);
        if (open_stop || phase_ms > probe_ms) begin
          set_bridge(drv_dir, 1'b0);
          seq_step = ST_WAIT_CONFIRM;
        end
      end
      ST_START_CLOSE: start_move(1'b0, ST_CLOSING);
      ST_CLOSING: begin
        phase_ms = sat_ms(phase_ms);
        if (close_stop) begin
          set_bridge(drv_dir, 1'b0);
          seq_step = ST_START_TOPEN;
        end else if (phase_ms > tmo_ms) begin
          halt_fault();
        end
      end
      ST_START_TOPEN: start_move(1'b1, ST_TIMED_OPEN);
      ST_TIMED_OPEN: begin
        phase_ms = sat_ms(phase_ms);
        if (open_stop) begin
          set_bridge(drv_dir, 1'b0);
          open_ms = phase_ms;
          if (open_ms < min_ms) seq_step = ST_RETRY_OPEN;
          else seq_step = ST_START_REOPEN;
        end else if (phase_ms > tmo_ms) begin
          halt_fault();
        end
      end
      ST_RETRY_OPEN: seq_step = ST_START_CLOSE;
      ST_START_REOPEN: start_move(1'b1, ST_REOPENING);
      ST_REOPENING: begin
        phase_ms = sat_ms(phase_ms);
        if (open_stop) begin
          set_bridge(drv_dir, 1'b0);
          seq_step = ST_START_TCLOSE;
        end else if (phase_ms > tmo_ms) begin
          halt_fault();
        end
      end
      ST_START_TCLOSE: start_move(1'b0, ST_TIMED_CLOSE);
      ST_TIMED_CLOSE: begin
        phase_ms = sat_ms(phase_ms);
        if (close_stop) begin
          set_bridge(drv_dir, 1'b0);
          close_ms = phase_ms;
          if (close_ms < min_ms) seq_step = ST_RETRY_CLOSE;
          else seq_step = ST_START_PARK;
        end else if (phase_ms > tmo_ms) begin
          halt_fault();
        end
      end
      ST_RETRY_CLOSE: seq_step = ST_START_REOPEN;
      ST_START_PARK: start_move(1'b1, ST_PARKING);
      ST_PARKING: begin
        phase_ms = sat_ms(phase_ms);
        if (phase_ms > probe_ms) begin
          set_bridge(drv_dir, 1'b0);
          seq_step = ST_IDLE;
          fin = 1'b1;
        end
      end
      default: halt_fault();
    endcase

    st.dir = drv_dir;
    st.speed = drv_on ? SPEED_FULL : SPEED_OFF;
    st.step = seq_step;
    st.waiting = (seq_step == ST_WAIT_CONFIRM);
    st.busy = (seq_step != ST_IDLE);
    st.fault = (seq_step == ST_ERROR);
    st.done = fin;
    st.open_ms = open_ms;
    st.close_ms = close_ms;
    pending_status.push_back(st);
  endtask

  // current drawn by the leaf: quiet while travelling but for short spikes,
  // over the threshold once it reaches the stop it is driven against; random when noisy
  function automatic cur_t motor_current(input bit noisy);
    int mag;
    int lim;
    if (drv_on && (!was_on || drv_dir != was_dir))
      travel_left = $urandom_range(0, travel_span);
    was_on = drv_on;
    was_dir = drv_dir;
    lim = int'(thr_ma) + 1;
    if (lim > 3200) lim = 3200;
    if (noisy && $urandom_range(0, 4) == 0) begin
      mag = $urandom_range(0, 6400);
      return cur_t'(mag - 3200);
    end
    if (drv_on && travel_left == 0) begin
      mag = $urandom_range(lim, 3200);
      return drv_dir ? cur_t'(mag) : cur_t'(-mag);
    end
    if (drv_on) begin
      travel_left--;
      // short spike, resets the hold count on the next quiet tick
      if ($urandom_range(0, 7) == 0) begin
        mag = $urandom_range(lim, 3200);
        return drv_dir ? cur_t'(mag) : cur_t'(-mag);
      end
    end
    mag = $urandom_range(0, int'(thr_ma));
    return $urandom_range(0, 1) ? cur_t'(mag) : cur_t'(-mag);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("result %0d: %s is %0d, expected %0d", beat_no, field, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input cmd_t cmd, input cur_t cur);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_current_ma <= cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_sequencer(cmd, cur);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_CURRENT: thr_ma = val[THR_BITS-1:0];
      CFG_OVER_TORQUE: torque_ms = val;
      CFG_MIN_TRAVEL:  min_ms = val;
      CFG_FIRST_OPEN:  probe_ms = val;
      CFG_TRAVEL_TMO:  tmo_ms = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending and let every expected status beat come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // commands that do nothing while idle, and the current extremes
  task automatic test_idle_commands();
    send_beat(CMD_TICK, 13'sd3200);
    send_beat(CMD_TICK, -13'sd3200);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_TICK, -13'sd1);
    send_beat(CMD_CONFIRM, 13'sd1);
    send_beat(CMD_CANCEL, -13'sd2);
  endtask

  // zero probe and zero travel limit: closing faults on its first tick
  task automatic test_timeout_zero();
    wait_quiet();
    write_reg(CFG_FIRST_OPEN, 16'd0);
    write_reg(CFG_TRAVEL_TMO, 16'd0);
    send_beat(CMD_START, 13'sd3200);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_CONFIRM, -13'sd3200);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_CONFIRM, 13'sd0);
    send_beat(CMD_START, 13'sd0);
    send_beat(CMD_CANCEL, 13'sd0);
  endtask

  // close stop and travel timeout on the same tick: the stop wins
  task automatic test_stop_beats_timeout();
    wait_quiet();
    write_reg(CFG_TRAVEL_TMO, 16'd1);
    send_beat(CMD_START, 13'sd0);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_CONFIRM, 13'sd0);
    send_beat(CMD_TICK, -13'sd100);
    send_beat(CMD_TICK, -13'sd100);
    send_beat(CMD_TICK, 13'sd0);
    send_beat(CMD_CANCEL, 13'sd0);
  endtask

  // whole calibration runs under random settings, some of them noisy
  task automatic test_random_runs();
    int first;
    int budget;
    int n;
    int sel;
    bit noisy;
    cmd_t cmd;
    first = items_sent;
    while (items_sent - first < 520) begin
      wait_quiet();
      sel = $urandom_range(0, 9);
      write_reg(CFG_MAX_CURRENT, sel == 0 ? 16'd0 : sel == 1 ? 16'd3200 :
                16'($urandom_range(10, 400)));
      sel = $urandom_range(0, 9);
      write_reg(CFG_OVER_TORQUE, sel == 0 ? 16'hFFFF : 16'($urandom_range(0, 3)));
      sel = $urandom_range(0, 9);
      write_reg(CFG_MIN_TRAVEL, sel == 0 ? 16'hFFFF : sel == 1 ? 16'd0 :
                16'($urandom_range(0, 12)));
      sel = $urandom_range(0, 9);
      write_reg(CFG_FIRST_OPEN, sel == 0 ? 16'hFFFF : sel == 1 ? 16'd0 :
                16'($urandom_range(0, 8)));
      sel = $urandom_range(0, 9);
      write_reg(CFG_TRAVEL_TMO, sel == 0 ? 16'hFFFF : sel == 1 ? 16'd0 :
                16'($urandom_range(3, 40)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      travel_span = $urandom_range(0, 24);
      budget = $urandom_range(30, 120);
      noisy = ($urandom_range(0, 4) == 0);

      send_beat(CMD_START, motor_current(noisy));
      n = 0;
      while (n < budget && seq_step != ST_IDLE) begin
        cmd = CMD_TICK;
        if (seq_step == ST_WAIT_CONFIRM && $urandom_range(0, 2) == 0)
          cmd = CMD_CONFIRM;
        if (seq_step == ST_ERROR && $urandom_range(0, 3) == 0)
          cmd = $urandom_range(0, 1) ? CMD_START : CMD_CANCEL;
        if (noisy && $urandom_range(0, 9) == 0)
          cmd = cmd_t'($urandom_range(0, 3));
        else if ($urandom_range(0, 99) == 0)
          cmd = CMD_CANCEL;
        send_beat(cmd, motor_current(noisy));
        n++;
        if ($urandom_range(0, 149) == 0) wait_quiet();
      end
      if (seq_step != ST_IDLE) send_beat(CMD_CANCEL, motor_current(noisy));
    end
  endtask

  // longest hold time and no timeout: over-current in either direction
  // never latches a stop, so closing just keeps running
  task automatic test_long_hold();
    wait_quiet();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CFG_MAX_CURRENT, 16'd100);
    write_reg(CFG_OVER_TORQUE, 16'hFFFF);
    write_reg(CFG_MIN_TRAVEL, 16'd0);
    write_reg(CFG_FIRST_OPEN, 16'd2);
    write_reg(CFG_TRAVEL_TMO, 16'hFFFF);
    send_beat(CMD_START, 13'sd0);
    while (seq_step != ST_WAIT_CONFIRM) send_beat(CMD_TICK, 13'sd0);
    // hold off until the block has answered everything so far
    wait_quiet();
    send_beat(CMD_CONFIRM, 13'sd0);
    repeat (30) send_beat(CMD_TICK, 13'sd200);
    repeat (30) send_beat(CMD_TICK, -13'sd200);
    send_beat(CMD_CANCEL, 13'sd0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : rx_side
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_status.pop_front();
        if (out_motor_dir !== want.dir)
          report_mismatch("motor_dir", out_motor_dir, want.dir);
        if (out_motor_speed !== want.speed)
          report_mismatch("motor_speed", out_motor_speed, want.speed);
        if (out_step_code !== want.step)
          report_mismatch("step_code", out_step_code, want.step);
        if (out_waiting_confirm !== want.waiting)
          report_mismatch("waiting_confirm", out_waiting_confirm, want.waiting);
        if (out_busy_res !== want.busy)
          report_mismatch("busy_res", out_busy_res, want.busy);
        if (out_fault !== want.fault)
          report_mismatch("fault", out_fault, want.fault);
        if (out_finished !== want.done)
          report_mismatch("finished", out_finished, want.done);
        if (out_open_time_ms !== want.open_ms)
          report_mismatch("open_time_ms", out_open_time_ms, want.open_ms);
        if (out_close_time_ms !== want.close_ms)
          report_mismatch("close_time_ms", out_close_time_ms, want.close_ms);
      end
      beat_no++;
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_timeout_zero();
    test_stop_beats_timeout();
    test_random_runs();
    test_long_hold();
    wait_quiet();
    if (pending_status.size() != 0)
      report_mismatch("beats still expected", pending_status.size(), 0);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
